// ===== rtl/pncs_pkg.sv =====
// shared types, constants and helpers for the nearest palette color search
// no dependencies

package pncs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PORT_IDX_W      = 8;
  localparam int CH_W            = 8;
  localparam int SQ_W            = 2 * CH_W;
  localparam int DIST_W          = 18;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // per-cell control: shift is shared by every cell of the ring, load is decoded per cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // valid and palette index that ride along the distance pipeline
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] tag;
  } tap_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // 5-bit channel to byte: shift left three and add 4
  function automatic logic [CH_W-1:0] widen5(input logic [4:0] c);
    widen5 = {c, 3'b100};
  endfunction

  function automatic logic [PORT_IDX_W-1:0] idx_to_port(input logic [IDX_W-1:0] i);
    logic [PORT_IDX_W-1:0] r;
    r = '0;
    r[IDX_W-1:0] = i;
    idx_to_port = r;
  endfunction

endpackage

// ===== rtl/pncs_cell.sv =====
// one palette entry of the rotating ring
// depends on pncs_pkg

module pncs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pncs_pkg::cell_ctl_t ctl,
  input  pncs_pkg::rgb_t     load_data,
  input  pncs_pkg::rgb_t     from_next,
  output pncs_pkg::rgb_t     entry
);

  pncs_pkg::rgb_t entry_r;
  pncs_pkg::rgb_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = load_data;
    end else if (ctl.shift) begin
      entry_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

// ===== rtl/pncs_dist.sv =====
// three-stage squared rgb distance: abs difference, square, sum
// depends on pncs_pkg

module pncs_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pncs_pkg::tap_t                tap_in,
  input  pncs_pkg::rgb_t                entry,
  input  pncs_pkg::rgb_t                query,
  output pncs_pkg::tap_t                tap_out,
  output logic [pncs_pkg::DIST_W-1:0]   sq_dist
);

  pncs_pkg::tap_t tap1_r, tap2_r, tap3_r;

  logic [pncs_pkg::CH_W-1:0] dr_nxt, dg_nxt, db_nxt;
  logic [pncs_pkg::CH_W-1:0] dr_r, dg_r, db_r;
  logic [pncs_pkg::SQ_W-1:0] sr_nxt, sg_nxt, sb_nxt;
  logic [pncs_pkg::SQ_W-1:0] sr_r, sg_r, sb_r;
  logic [pncs_pkg::DIST_W-1:0] sum_nxt, sum_r;

  always_comb begin
    dr_nxt = (query.red > entry.red)     ? query.red - entry.red     : entry.red - query.red;
    dg_nxt = (query.green > entry.green) ? query.green - entry.green : entry.green - query.green;
    db_nxt = (query.blue > entry.blue)   ? query.blue - entry.blue   : entry.blue - query.blue;
  end

  always_comb begin
    sr_nxt = {{pncs_pkg::CH_W{1'b0}}, dr_r} * {{pncs_pkg::CH_W{1'b0}}, dr_r};
    sg_nxt = {{pncs_pkg::CH_W{1'b0}}, dg_r} * {{pncs_pkg::CH_W{1'b0}}, dg_r};
    sb_nxt = {{pncs_pkg::CH_W{1'b0}}, db_r} * {{pncs_pkg::CH_W{1'b0}}, db_r};
  end

  always_comb begin
    sum_nxt = {2'b00, sr_r} + {2'b00, sg_r} + {2'b00, sb_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap1_r <= '0;
      tap2_r <= '0;
      tap3_r <= '0;
    end else begin
      tap1_r <= tap_in;
      tap2_r <= tap1_r;
      tap3_r <= tap2_r;
    end
  end

  always_ff @(posedge clk) begin
    dr_r  <= dr_nxt;
    dg_r  <= dg_nxt;
    db_r  <= db_nxt;
    sr_r  <= sr_nxt;
    sg_r  <= sg_nxt;
    sb_r  <= sb_nxt;
    sum_r <= sum_nxt;
  end

  assign tap_out = tap3_r;
  assign sq_dist = sum_r;

endmodule

// ===== rtl/nearest_palette_color_search_top.sv =====
// nearest palette color search: palette ring of cells, distance pipeline, best tracker
// depends on pncs_pkg, pncs_cell, pncs_dist
// load: writes one entry, no result. query: the ring makes one full turn, each entry passes the
// 3 distance stages and the compare, and the best is then loaded into the output register
// one item at a time; after a query the input stays stalled until the result is loaded,
// with the ring rotating one entry per cycle during the scan. synchronous active-low reset zeroes every entry

module nearest_palette_color_search_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_entry_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [14:0] in_query_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_nearest_index,
  output logic [17:0] out_nearest_distance
);

  // control state
  pncs_pkg::state_t state_r, state_nxt;
  logic [pncs_pkg::IDX_W-1:0] cnt_r, cnt_nxt;

  // handshake decode
  logic in_xfer, out_xfer, load_hit, query_hit;
  logic shift_en, feed_vld, res_load, slot_free, last_seen;

  // query color, widened at transfer
  pncs_pkg::rgb_t query_r, query_nxt;

  // palette ring: cell i takes from cell i+1, cell 0 is the head
  pncs_pkg::rgb_t pal [pncs_pkg::PALETTE_ENTRIES];
  pncs_pkg::rgb_t load_data;

  // distance pipeline
  pncs_pkg::tap_t tap_in, tap_out;
  logic [pncs_pkg::DIST_W-1:0] entry_dist;

  // running best
  logic [pncs_pkg::IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [pncs_pkg::DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic                        best_upd;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_idx_r, out_idx_nxt;
  logic [pncs_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign load_hit  = in_xfer && (in_operation == pncs_pkg::OP_LOAD);
  assign query_hit = in_xfer && (in_operation == pncs_pkg::OP_QUERY);
  assign slot_free = !out_valid_r || !out_stall;
  assign last_seen = tap_out.vld && (tap_out.tag == pncs_pkg::LAST_IDX);

  assign load_data = '{red: in_red, green: in_green, blue: in_blue};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pncs_pkg::ST_IDLE: begin
        if (query_hit) state_nxt = pncs_pkg::ST_SCAN;
      end
      pncs_pkg::ST_SCAN: begin
        // ring is back home after exactly one full turn
        if (cnt_r == pncs_pkg::LAST_IDX) state_nxt = pncs_pkg::ST_DRAIN;
      end
      pncs_pkg::ST_DRAIN: begin
        if (last_seen) state_nxt = pncs_pkg::ST_RESULT;
      end
      pncs_pkg::ST_RESULT: begin
        // wait here while an older result is still held stalled in the output register
        if (slot_free) state_nxt = pncs_pkg::ST_IDLE;
      end
      default: state_nxt = pncs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    shift_en = 1'b0;
    feed_vld = 1'b0;
    res_load = 1'b0;
    unique case (state_r)
      pncs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      pncs_pkg::ST_SCAN: begin
        shift_en = 1'b1;
        feed_vld = 1'b1;
      end
      pncs_pkg::ST_DRAIN: begin
        in_stall = 1'b1;
      end
      pncs_pkg::ST_RESULT: begin
        res_load = slot_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // scan counter doubles as the index of the entry at the head
  always_comb begin
    cnt_nxt = cnt_r;
    if (query_hit) begin
      cnt_nxt = '0;
    end else if (shift_en) begin
      cnt_nxt = cnt_r + {{(pncs_pkg::IDX_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    query_nxt = query_r;
    if (query_hit) begin
      query_nxt.red   = pncs_pkg::widen5(in_query_color[4:0]);
      query_nxt.green = pncs_pkg::widen5(in_query_color[9:5]);
      query_nxt.blue  = pncs_pkg::widen5(in_query_color[14:10]);
    end
  end

  // palette cells; a load only lands in idle, when the ring sits at home
  for (genvar i = 0; i < pncs_pkg::PALETTE_ENTRIES; i++) begin : g_cell
    localparam int NB = (i + 1) % pncs_pkg::PALETTE_ENTRIES;
    pncs_pkg::cell_ctl_t ctl;
    assign ctl.shift = shift_en;
    assign ctl.load  = load_hit && (in_entry_index == 8'(i));
    pncs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_data (load_data),
      .from_next (pal[NB]),
      .entry     (pal[i])
    );
  end

  assign tap_in.vld = feed_vld;
  assign tap_in.tag = cnt_r;

  pncs_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tap_in  (tap_in),
    .entry   (pal[0]),
    .query   (query_r),
    .tap_out (tap_out),
    .sq_dist (entry_dist)
  );

  // strict less-than keeps the lowest index on ties
  always_comb begin
    best_upd      = tap_out.vld && ((tap_out.tag == '0) || (entry_dist < best_dist_r));
    best_idx_nxt  = best_upd ? tap_out.tag : best_idx_r;
    best_dist_nxt = best_upd ? entry_dist : best_dist_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = pncs_pkg::idx_to_port(best_idx_r);
      out_dist_nxt  = best_dist_r;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pncs_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    query_r     <= query_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;

  // the last entry leaves the distance pipeline only after the scan has ended
  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    last_seen |-> (state_r == pncs_pkg::ST_DRAIN))
    else $error("last distance outside drain");

  // a scan always starts with the head at entry zero
  a_scan_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    query_hit |=> (cnt_r == '0) && (state_r == pncs_pkg::ST_SCAN))
    else $error("scan did not start at entry zero");

  // a new result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !(out_valid_r && out_stall))
    else $error("result overwrote a pending transfer");

endmodule
